// ===== hdl/advection_diffusion_stencil_1d_assert.svh =====
// Assertion macros for the advection-diffusion stencil block.
`ifndef ADVECTION_DIFFUSION_STENCIL_1D_ASSERT_SVH
`define ADVECTION_DIFFUSION_STENCIL_1D_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ADST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ADST_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/adst_pkg.sv =====
// Shared types and constants of the advection-diffusion stencil block.
package adst_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int IDX_W      = 12;
  localparam int ADV_W      = 18;
  localparam int DIFF_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 18;

  localparam int LAP_W  = SAMPLE_W + 2;
  localparam int GRAD_W = SAMPLE_W + 1;
  localparam int PD_W   = DIFF_W + 1 + LAP_W;
  localparam int PA_W   = ADV_W + GRAD_W;
  localparam int ACC_W  = 37;
  localparam int RND_SH = 16;
  localparam int R_W    = ACC_W - RND_SH;
  localparam int SUM_W  = R_W + 1;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;
  localparam int QMAXWR  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADV_COEF  = 1'b0,
    CFG_DIFF_COEF = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    JOB_NORMAL  = 2'd0,
    JOB_DEFER   = 2'd1,
    JOB_RELEASE = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t                   kind;
    logic signed [SAMPLE_W-1:0]  left;
    logic signed [SAMPLE_W-1:0]  mid;
    logic signed [SAMPLE_W-1:0]  right;
    logic [IDX_W-1:0]            idx;
    logic                        run_last;
  } job_t;

  // Front to queue: up to three jobs, packed from slot 0.
  typedef struct packed {
    logic [1:0] num;
    job_t       job0;
    job_t       job1;
    job_t       job2;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_rd_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              room;
  } q_stat_t;

  typedef struct packed {
    logic pend;
    logic cnt_zero;
  } fr_stat_t;

endpackage

// ===== hdl/adst_if.sv =====
// Stream channel interfaces for samples in and updated points out.
interface adst_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [adst_pkg::SAMPLE_W-1:0] sample;
  logic                                row_end;

  modport source (output valid, output sample, output row_end, input ready);
  modport sink   (input valid, input sample, input row_end, output ready);
endinterface

interface adst_out_if;
  logic                                valid;
  logic                                ready;
  logic [adst_pkg::IDX_W-1:0]          point_index;
  logic signed [adst_pkg::SAMPLE_W-1:0] new_value;
  logic                                run_last;

  modport source (output valid, output point_index, output new_value, output run_last,
                  input ready);
  modport sink   (input valid, input point_index, input new_value, input run_last,
                  output ready);
endinterface

// ===== hdl/adst_front.sv =====
// Front end: takes sample beats, keeps the window and wrap samples, issues stencil jobs.
module adst_front #(
  parameter int MAX_POINTS = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  adst_in_if.sink             in_chan,
  input  logic                room,
  output adst_pkg::q_wr_t     q_wr,
  output adst_pkg::fr_stat_t  fr_stat
);

  localparam int CNT_W = $clog2(MAX_POINTS);
  localparam int EXT_W = CNT_W + adst_pkg::IDX_W;

  logic [CNT_W-1:0]                      cnt_r, cnt_nxt;
  logic                                  pend_r, pend_nxt;
  logic signed [adst_pkg::SAMPLE_W-1:0]  first_r, first_nxt;
  logic signed [adst_pkg::SAMPLE_W-1:0]  second_r, second_nxt;
  logic signed [adst_pkg::SAMPLE_W-1:0]  prev_r, prev_nxt;
  logic signed [adst_pkg::SAMPLE_W-1:0]  pprev_r, pprev_nxt;

  logic                 accept;
  logic                 last;
  logic                 interior;
  logic [CNT_W-1:0]     cnt_m1;
  logic [EXT_W-1:0]     cnt_ext;
  logic [EXT_W-1:0]     cnt_m1_ext;
  adst_pkg::job_t       job_a, job_b, job_d, job_rel;

  assign in_chan.ready = room;
  assign accept        = in_chan.valid & room;

  // Force a row end when the row reaches its maximum length.
  assign last     = in_chan.row_end | (cnt_r >= CNT_W'(MAX_POINTS - 1));
  assign interior = (cnt_r >= CNT_W'(2));
  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign cnt_ext    = {{adst_pkg::IDX_W{1'b0}}, cnt_r};
  assign cnt_m1_ext = {{adst_pkg::IDX_W{1'b0}}, cnt_m1};

  always_comb begin
    job_a.kind     = adst_pkg::JOB_NORMAL;
    job_a.left     = pprev_r;
    job_a.mid      = prev_r;
    job_a.right    = in_chan.sample;
    job_a.idx      = cnt_m1_ext[adst_pkg::IDX_W-1:0];
    job_a.run_last = 1'b0;

    job_b.kind     = adst_pkg::JOB_NORMAL;
    job_b.left     = prev_r;
    job_b.mid      = in_chan.sample;
    job_b.right    = first_r;
    job_b.idx      = cnt_ext[adst_pkg::IDX_W-1:0];
    job_b.run_last = 1'b0;

    // Point 0 of the finished row: compute now, hold the result until the next beat.
    job_d.kind     = adst_pkg::JOB_DEFER;
    job_d.left     = in_chan.sample;
    job_d.mid      = first_r;
    job_d.right    = second_r;
    job_d.idx      = '0;
    job_d.run_last = 1'b1;

    job_rel.kind     = adst_pkg::JOB_RELEASE;
    job_rel.left     = '0;
    job_rel.mid      = '0;
    job_rel.right    = '0;
    job_rel.idx      = '0;
    job_rel.run_last = 1'b1;
  end

  always_comb begin
    q_wr.job0 = pend_r ? job_rel : job_a;
    q_wr.job1 = job_b;
    q_wr.job2 = job_d;
    q_wr.num  = 2'd0;
    if (accept) begin
      if (pend_r) begin
        q_wr.num = 2'd1;
      end else if (interior) begin
        q_wr.num = last ? 2'd3 : 2'd1;
      end
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    prev_nxt   = prev_r;
    pprev_nxt  = pprev_r;
    if (accept) begin
      if (cnt_r == '0) begin
        first_nxt = in_chan.sample;
      end
      if (cnt_r == CNT_W'(1)) begin
        second_nxt = in_chan.sample;
      end
      pend_nxt  = interior & last;
      pprev_nxt = prev_r;
      prev_nxt  = in_chan.sample;
      cnt_nxt   = last ? '0 : cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      pend_r   <= 1'b0;
      first_r  <= '0;
      second_r <= '0;
      prev_r   <= '0;
      pprev_r  <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      pend_r   <= pend_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      prev_r   <= prev_nxt;
      pprev_r  <= pprev_nxt;
    end
  end

  assign fr_stat.pend     = pend_r;
  assign fr_stat.cnt_zero = (cnt_r == '0);

endmodule

// ===== hdl/adst_queue.sv =====
// Job queue between front and back end: up to three writes and one read per cycle.
module adst_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  adst_pkg::q_wr_t     q_wr,
  input  logic                pop,
  output adst_pkg::q_rd_t     q_rd,
  output adst_pkg::q_stat_t   q_stat
);

  adst_pkg::job_t mem_r [adst_pkg::QDEPTH];

  logic [adst_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [adst_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [adst_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic                        do_pop;

  assign do_pop     = pop & (count_r != '0);
  assign wr_ptr_nxt = wr_ptr_r + adst_pkg::QPTR_W'(q_wr.num);
  assign rd_ptr_nxt = rd_ptr_r + adst_pkg::QPTR_W'(do_pop);
  assign count_nxt  = count_r + adst_pkg::QCNT_W'(q_wr.num) - adst_pkg::QCNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (q_wr.num >= 2'd1) begin
      mem_r[wr_ptr_r] <= q_wr.job0;
    end
    if (q_wr.num >= 2'd2) begin
      mem_r[wr_ptr_r + adst_pkg::QPTR_W'(1)] <= q_wr.job1;
    end
    if (q_wr.num >= 2'd3) begin
      mem_r[wr_ptr_r + adst_pkg::QPTR_W'(2)] <= q_wr.job2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign q_rd.valid   = (count_r != '0);
  assign q_rd.job     = mem_r[rd_ptr_r];
  assign q_stat.count = count_r;
  // Accept a sample only when the largest burst of jobs still fits.
  assign q_stat.room  =
    (count_r <= adst_pkg::QCNT_W'(adst_pkg::QDEPTH - adst_pkg::QMAXWR));

endmodule

// ===== hdl/adst_back.sv =====
// Back end: four-stage stencil pipeline ending in the output register.
module adst_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  adst_pkg::q_rd_t                   q_rd,
  output logic                              pop,
  input  logic signed [adst_pkg::ADV_W-1:0] adv_coef,
  input  logic [adst_pkg::DIFF_W-1:0]       diff_coef,
  adst_out_if.source                        out_chan
);

  typedef struct packed {
    adst_pkg::job_kind_t                  kind;
    logic signed [adst_pkg::SAMPLE_W-1:0] mid;
    logic [adst_pkg::IDX_W-1:0]           idx;
    logic                                 run_last;
  } tag_t;

  logic advance;

  // Stage 1: Laplacian and gradient
  logic                                 s1_valid_r;
  tag_t                                 s1_tag_r;
  logic signed [adst_pkg::LAP_W-1:0]    s1_lap_r, s1_lap_nxt;
  logic signed [adst_pkg::GRAD_W-1:0]   s1_grad_r, s1_grad_nxt;

  // Stage 2: products
  logic                                 s2_valid_r;
  tag_t                                 s2_tag_r;
  logic signed [adst_pkg::PD_W-1:0]     s2_pd_r, s2_pd_nxt;
  logic signed [adst_pkg::PA_W-1:0]     s2_pa_r, s2_pa_nxt;

  // Stage 3: rounded correction
  logic                                 s3_valid_r;
  tag_t                                 s3_tag_r;
  logic signed [adst_pkg::R_W-1:0]      s3_r_r, s3_r_nxt;

  // Stage 4: output register and held point-0 result
  logic                                 out_valid_r, out_valid_nxt;
  logic [adst_pkg::IDX_W-1:0]           out_idx_r, out_idx_nxt;
  logic signed [adst_pkg::SAMPLE_W-1:0] out_val_r, out_val_nxt;
  logic                                 out_last_r, out_last_nxt;
  logic signed [adst_pkg::SAMPLE_W-1:0] pend_res_r, pend_res_nxt;

  logic signed [adst_pkg::DIFF_W:0]     diff_s;
  logic signed [adst_pkg::ACC_W-1:0]    acc;
  logic signed [adst_pkg::ACC_W-1:0]    rnd;
  logic signed [adst_pkg::SUM_W-1:0]    sum;
  logic signed [adst_pkg::SAMPLE_W-1:0] sat;
  tag_t                                 q_tag;

  // Freeze the whole pipe while a result beat waits.
  assign advance = ~out_valid_r | out_chan.ready;
  assign pop     = advance & q_rd.valid;

  assign q_tag.kind     = q_rd.job.kind;
  assign q_tag.mid      = q_rd.job.mid;
  assign q_tag.idx      = q_rd.job.idx;
  assign q_tag.run_last = q_rd.job.run_last;

  assign s1_lap_nxt = adst_pkg::LAP_W'(q_rd.job.right) + adst_pkg::LAP_W'(q_rd.job.left)
                    - (adst_pkg::LAP_W'(q_rd.job.mid) <<< 1);
  assign s1_grad_nxt = adst_pkg::GRAD_W'(q_rd.job.right) - adst_pkg::GRAD_W'(q_rd.job.left);

  assign diff_s    = {1'b0, diff_coef};
  assign s2_pd_nxt = diff_s * s1_lap_r;
  assign s2_pa_nxt = adv_coef * s1_grad_r;

  // Round half up at bit 16 by adding 2^15, then floor by the arithmetic shift.
  assign acc      = adst_pkg::ACC_W'(s2_pd_r) - adst_pkg::ACC_W'(s2_pa_r);
  assign rnd      = acc + adst_pkg::ACC_W'(32768);
  assign s3_r_nxt = rnd[adst_pkg::ACC_W-1:adst_pkg::RND_SH];

  assign sum = adst_pkg::SUM_W'(s3_tag_r.mid) + adst_pkg::SUM_W'(s3_r_r);

  always_comb begin
    if (sum > adst_pkg::SUM_W'(32767)) begin
      sat = 16'sh7FFF;
    end else if (sum < -adst_pkg::SUM_W'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[adst_pkg::SAMPLE_W-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = 1'b0;
    out_idx_nxt   = s3_tag_r.idx;
    out_val_nxt   = sat;
    out_last_nxt  = s3_tag_r.run_last;
    pend_res_nxt  = pend_res_r;
    if (s3_valid_r) begin
      unique case (s3_tag_r.kind)
        adst_pkg::JOB_NORMAL: begin
          out_valid_nxt = 1'b1;
        end
        adst_pkg::JOB_DEFER: begin
          pend_res_nxt = sat;
        end
        adst_pkg::JOB_RELEASE: begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = '0;
          out_val_nxt   = pend_res_r;
          out_last_nxt  = 1'b1;
        end
        default: begin
          out_valid_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= q_rd.valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_tag_r   <= q_tag;
      s1_lap_r   <= s1_lap_nxt;
      s1_grad_r  <= s1_grad_nxt;
      s2_tag_r   <= s1_tag_r;
      s2_pd_r    <= s2_pd_nxt;
      s2_pa_r    <= s2_pa_nxt;
      s3_tag_r   <= s2_tag_r;
      s3_r_r     <= s3_r_nxt;
      out_idx_r  <= out_idx_nxt;
      out_val_r  <= out_val_nxt;
      out_last_r <= out_last_nxt;
      pend_res_r <= pend_res_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.point_index = out_idx_r;
  assign out_chan.new_value   = out_val_r;
  assign out_chan.run_last    = out_last_r;

endmodule

// ===== hdl/advection_diffusion_stencil_1d.sv =====
// Top level of the periodic 1-D advection-diffusion stencil.
// One FTCS step over a periodic row: samples stream in point order, one beat per cycle while
// the job queue has room, and each updated point leaves as new = u + b*(u_next - 2u + u_prev) -
// a*(u_next - u_prev), rounded half up to a signed 16-bit integer (Q16.0) and saturated.
// Point i (1..N-2) leaves after sample i+1 arrives, the row_end sample releases points N-2
// and N-1, and point 0 (flagged run_last) leaves only after the first sample of the next row
// is accepted. Rows of fewer than three samples give nothing; a row reaching MAX_POINTS
// samples ends there. Rate: the back end runs one stencil job per cycle while the output is
// not stalled, through a four-stage pipeline (difference, multiply, round, saturate into the
// output register); every interior sample makes one job, the row_end sample three, the first
// sample of a row one more. A four-entry job queue holds jobs while the output stalls; the
// input waits once two jobs are queued. Write adv_coef and diff_coef only with the block idle.
module advection_diffusion_stencil_1d #(
  parameter int MAX_POINTS = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  adst_in_if.sink                              in_chan,
  adst_out_if.source                           out_chan,
  input  logic                                 cfg_we,
  input  logic [adst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [adst_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic signed [adst_pkg::ADV_W-1:0] adv_coef_r, adv_coef_nxt;
  logic [adst_pkg::DIFF_W-1:0]       diff_coef_r, diff_coef_nxt;

  adst_pkg::q_wr_t    q_wr;
  adst_pkg::q_rd_t    q_rd;
  adst_pkg::q_stat_t  q_stat;
  adst_pkg::fr_stat_t fr_stat;
  logic               pop;

  always_comb begin
    adv_coef_nxt  = adv_coef_r;
    diff_coef_nxt = diff_coef_r;
    if (cfg_we) begin
      unique case (adst_pkg::cfg_reg_t'(cfg_index))
        adst_pkg::CFG_ADV_COEF: begin
          adv_coef_nxt = cfg_wdata[adst_pkg::ADV_W-1:0];
        end
        adst_pkg::CFG_DIFF_COEF: begin
          diff_coef_nxt = cfg_wdata[adst_pkg::DIFF_W-1:0];
        end
        default: begin
          adv_coef_nxt = adv_coef_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adv_coef_r  <= '0;
      diff_coef_r <= '0;
    end else begin
      adv_coef_r  <= adv_coef_nxt;
      diff_coef_r <= diff_coef_nxt;
    end
  end

  adst_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .room    (q_stat.room),
    .q_wr    (q_wr),
    .fr_stat (fr_stat)
  );

  adst_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .pop    (pop),
    .q_rd   (q_rd),
    .q_stat (q_stat)
  );

  adst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rd      (q_rd),
    .pop       (pop),
    .adv_coef  (adv_coef_r),
    .diff_coef (diff_coef_r),
    .out_chan  (out_chan)
  );

`include "advection_diffusion_stencil_1d_assert.svh"

  `ADST_ASSERT_IMP(a_queue_bound, 1'b1, q_stat.count <= adst_pkg::QCNT_W'(adst_pkg::QDEPTH), "job queue overflow")
  `ADST_ASSERT_IMP(a_pend_at_row_start, fr_stat.pend, fr_stat.cnt_zero, "point 0 held mid-row")
  `ADST_ASSERT_NXT(a_pend_clears, fr_stat.pend && in_chan.valid && in_chan.ready, !fr_stat.pend, "held point 0 not released")
  `ADST_ASSERT_IMP(a_last_is_point0, out_chan.valid && out_chan.run_last, out_chan.point_index == '0, "run_last beat not point 0")

endmodule

// ===== tb/advection_diffusion_stencil_1d_tb.sv =====
// Testbench for the periodic 1-D advection-diffusion stencil: random rows, scoreboard check.
module advection_diffusion_stencil_1d_tb;

  localparam int ROW_LIMIT   = 4096;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 16;
  localparam int PHASE_ITEMS = 130;

  typedef struct {
    logic [adst_pkg::IDX_W-1:0]           idx;
    logic signed [adst_pkg::SAMPLE_W-1:0] value;
    logic                                 last;
  } grid_point_t;

  // Predicts updated grid points from the accepted samples and checks the outgoing ones.
  class stencil_scoreboard;
    grid_point_t                           due_points[$];
    logic signed [adst_pkg::ADV_W-1:0]     adv;
    logic [adst_pkg::DIFF_W-1:0]           diff;
    logic signed [adst_pkg::SAMPLE_W-1:0]  row_first;
    logic signed [adst_pkg::SAMPLE_W-1:0]  row_second;
    logic signed [adst_pkg::SAMPLE_W-1:0]  last_s;
    logic signed [adst_pkg::SAMPLE_W-1:0]  last_last_s;
    int unsigned                           seen;
    logic signed [adst_pkg::SAMPLE_W-1:0]  held_p0;
    bit                                    held_valid;
    int                                    errors;
    int                                    row_limit;

    function new(int limit);
      row_limit   = limit;
      adv         = '0;
      diff        = '0;
      row_first   = '0;
      row_second  = '0;
      last_s      = '0;
      last_last_s = '0;
      seen        = 0;
      held_p0     = '0;
      held_valid  = 0;
      errors      = 0;
    endfunction

    function void set_coef(adst_pkg::cfg_reg_t r, logic [adst_pkg::CFG_DATA_W-1:0] v);
      if (r == adst_pkg::CFG_ADV_COEF) adv = v[adst_pkg::ADV_W-1:0];
      else diff = v[adst_pkg::DIFF_W-1:0];
    endfunction

    // One FTCS update: exact product sum, round half up at bit 16, saturate.
    function logic signed [adst_pkg::SAMPLE_W-1:0] next_value(
        logic signed [adst_pkg::SAMPLE_W-1:0] l,
        logic signed [adst_pkg::SAMPLE_W-1:0] m,
        logic signed [adst_pkg::SAMPLE_W-1:0] r);
      longint lap, grad, acc, rnd, v;
      lap  = longint'(r) - 2 * longint'(m) + longint'(l);
      grad = longint'(r) - longint'(l);
      acc  = longint'(diff) * lap - longint'(adv) * grad;
      rnd  = (acc + 32768) >>> 16;
      v    = longint'(m) + rnd;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[adst_pkg::SAMPLE_W-1:0];
    endfunction

    function void add_point(int unsigned idx, logic signed [adst_pkg::SAMPLE_W-1:0] value,
                            logic last);
      grid_point_t p;
      p.idx   = idx[adst_pkg::IDX_W-1:0];
      p.value = value;
      p.last  = last;
      due_points.push_back(p);
    endfunction

    function void note_sample(logic signed [adst_pkg::SAMPLE_W-1:0] s, logic row_end);
      bit ends;
      ends = row_end || (seen >= row_limit - 1);
      // the held point 0 of the previous row leaves ahead of anything else
      if (held_valid) begin
        add_point(0, held_p0, 1'b1);
        held_valid = 0;
      end
      if (seen == 0) row_first = s;
      else if (seen == 1) row_second = s;
      if (seen >= 2) begin
        add_point(seen - 1, next_value(last_last_s, last_s, s), 1'b0);
        if (ends) begin
          add_point(seen, next_value(last_s, s, row_first), 1'b0);
          held_p0    = next_value(s, row_first, row_second);
          held_valid = 1;
        end
      end
      last_last_s = last_s;
      last_s      = s;
      seen        = ends ? 0 : seen + 1;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_point(logic [adst_pkg::IDX_W-1:0] idx,
                     logic signed [adst_pkg::SAMPLE_W-1:0] value, logic last);
      grid_point_t e;
      if (due_points.size() == 0) begin
        report($sformatf("unexpected point idx=%0d value=%0d last=%0b", idx, value, last));
        return;
      end
      e = due_points.pop_front();
      if (idx !== e.idx)
        report($sformatf("point_index got %0d want %0d", idx, e.idx));
      if (value !== e.value)
        report($sformatf("new_value at idx %0d got %0d want %0d", e.idx, value, e.value));
      if (last !== e.last)
        report($sformatf("run_last at idx %0d got %0b want %0b", e.idx, last, e.last));
    endtask

    function int outstanding();
      return due_points.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [adst_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [adst_pkg::CFG_DATA_W-1:0] cfg_wdata;
  bit                              steady;
  int                              cycles = 0;
  int                              sink_hold;

  adst_in_if  in_chan ();
  adst_out_if out_chan ();

  stencil_scoreboard sb = new(ROW_LIMIT);

  advection_diffusion_stencil_1d #(
    .MAX_POINTS(ROW_LIMIT)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: ready drops in random bursts until the steady stretch.
  initial begin
    out_chan.ready = 1'b0;
    sink_hold      = 0;
    forever begin
      @(posedge clk);
      if (!steady && sink_hold == 0 && $urandom_range(0, 5) == 0)
        sink_hold = $urandom_range(1, 6);
      if (sink_hold > 0) begin
        out_chan.ready <= 1'b0;
        sink_hold--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_point(out_chan.point_index, out_chan.new_value, out_chan.run_last);
  end

  task automatic push_sample(logic signed [adst_pkg::SAMPLE_W-1:0] s, logic row_end);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.sample  <= s;
    in_chan.row_end <= row_end;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_sample(s, row_end);
  endtask

  // Drop valid, drain all due points, then give the pipeline time to empty.
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_coefs(int adv, int diff);
    cfg_we    <= 1'b1;
    cfg_index <= adst_pkg::CFG_ADV_COEF;
    cfg_wdata <= adv[adst_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    sb.set_coef(adst_pkg::CFG_ADV_COEF, adv[adst_pkg::CFG_DATA_W-1:0]);
    cfg_index <= adst_pkg::CFG_DIFF_COEF;
    cfg_wdata <= diff[adst_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    sb.set_coef(adst_pkg::CFG_DIFF_COEF, diff[adst_pkg::CFG_DATA_W-1:0]);
    cfg_we <= 1'b0;
  endtask

  // Short rows, a three-point row and a row of alternating extremes.
  task automatic run_directed();
    push_sample(16'sh7fff, 1'b1);
    push_sample(-16'sd32768, 1'b0);
    push_sample(16'sh7fff, 1'b1);
    push_sample(16'sh7fff, 1'b0);
    push_sample(-16'sd32768, 1'b0);
    push_sample(16'sh7fff, 1'b1);
    push_sample(-16'sd32768, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(-16'sd32768, 1'b0);
    push_sample(16'sd0, 1'b0);
    push_sample(16'sd1, 1'b1);
  endtask

  task automatic send_random_row(int len);
    int mode;
    logic signed [adst_pkg::SAMPLE_W-1:0] s;
    mode = $urandom_range(0, 2);
    s    = adst_pkg::SAMPLE_W'($urandom);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: s = adst_pkg::SAMPLE_W'($urandom);
        1: begin
          case ($urandom_range(0, 4))
            0: s = 16'sh7fff;
            1: s = -16'sd32768;
            2: s = 16'sd0;
            3: s = -16'sd1;
            default: s = 16'sd16384;
          endcase
        end
        default: s = adst_pkg::SAMPLE_W'(s + $urandom_range(0, 64) - 32);
      endcase
      push_sample(s, i == len - 1);
    end
  endtask

  task automatic run_phase(int adv, int diff, int n_items);
    int sent;
    int pick;
    int len;
    settle();
    write_coefs(adv, diff);
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) len = $urandom_range(1, 2);
      else if (pick < 8) len = $urandom_range(3, 12);
      else len = $urandom_range(13, 60);
      send_random_row(len);
      sent += len;
    end
  endtask

  function automatic int rand_adv();
    return int'($urandom_range(0, 262143)) - 131072;
  endfunction

  initial begin
    rst_n           = 1'b0;
    steady          = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = adst_pkg::CFG_ADV_COEF;
    cfg_wdata       = '0;
    in_chan.valid   = 1'b0;
    in_chan.sample  = '0;
    in_chan.row_end = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_coefs(-131072, 65535);
    run_directed();
    settle();
    write_coefs(131071, 0);
    run_directed();

    run_phase(0, 0, PHASE_ITEMS);
    run_phase(131071, 65535, PHASE_ITEMS);
    run_phase(-131072, 0, PHASE_ITEMS);
    run_phase(rand_adv(), $urandom_range(0, 65535), PHASE_ITEMS);
    run_phase(rand_adv() >>> 4, $urandom_range(0, 16384), PHASE_ITEMS);
    run_phase(rand_adv(), $urandom_range(0, 65535), PHASE_ITEMS);
    run_phase(rand_adv(), $urandom_range(0, 65535), PHASE_ITEMS);
    steady = 1'b1;
    run_phase(rand_adv(), $urandom_range(0, 65535), PHASE_ITEMS);
    settle();

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/adst_pkg.sv
hdl/adst_if.sv
hdl/adst_front.sv
hdl/adst_queue.sv
hdl/adst_back.sv
hdl/advection_diffusion_stencil_1d.sv
tb/advection_diffusion_stencil_1d_tb.sv
